>>> hdl/bsv_pkg.sv
// Package for the bounding-sphere visibility core: widths, result codes,
// register indexes and the shared arithmetic helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsv_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Quotient magnitude width: a 31-bit scale times a 32-bit magnitude.
    localparam int NUM_W = 62;
    // Divisor and remainder width: a positive 32-bit depth.
    localparam int REM_W = 31;
    // Screen point width, wide enough for a quotient plus an offset.
    localparam int PT_W = 66;
    localparam int NDIV = 4;

    typedef enum logic [1:0] {
        VIS_NONE    = 2'd0,
        VIS_PARTIAL = 2'd1,
        VIS_FULL    = 2'd2
    } vis_t;

    localparam logic [2:0] REG_NEAR   = 3'd0;
    localparam logic [2:0] REG_HSCALE = 3'd1;
    localparam logic [2:0] REG_VSCALE = 3'd2;
    localparam logic [2:0] REG_LEFT   = 3'd3;
    localparam logic [2:0] REG_RIGHT  = 3'd4;
    localparam logic [2:0] REG_TOP    = 3'd5;
    localparam logic [2:0] REG_BOTTOM = 3'd6;

    // One restoring division step: returns {remainder, shifted numerator}
    // with the new quotient bit entering at the bottom of the numerator.
    function automatic logic [REM_W+NUM_W-1:0] div_step(
        input logic [REM_W-1:0] rem,
        input logic [NUM_W-1:0] num,
        input logic [REM_W-1:0] d
    );
        logic [REM_W:0] t;
        logic [REM_W:0] diff;
        logic           ge;
        t    = {rem, num[NUM_W-1]};
        diff = t - {1'b0, d};
        ge   = (t >= {1'b0, d});
        if (ge)
        begin
            div_step = {diff[REM_W-1:0], num[NUM_W-2:0], 1'b1};
        end
        else
        begin
            div_step = {t[REM_W-1:0], num[NUM_W-2:0], 1'b0};
        end
    endfunction

    // Outcode bits: left, right, top, bottom. A point on a bound is inside.
    function automatic logic [3:0] outcode(
        input logic signed [PT_W-1:0] x,
        input logic signed [PT_W-1:0] y,
        input logic signed [31:0]     l,
        input logic signed [31:0]     r,
        input logic signed [31:0]     t,
        input logic signed [31:0]     b
    );
        logic signed [PT_W-1:0] le;
        logic signed [PT_W-1:0] re;
        logic signed [PT_W-1:0] te;
        logic signed [PT_W-1:0] be;
        le = PT_W'(l);
        re = PT_W'(r);
        te = PT_W'(t);
        be = PT_W'(b);
        outcode = {y > be, y < te, x > re, x < le};
    endfunction

endpackage

`default_nettype wire

>>> hdl/bounding_sphere_visibility_core.sv
// Top level of the bounding-sphere visibility core: configuration registers,
// effective radius, near-plane test, pipelined division and viewport outcodes.
// Depends on bsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The core accepts one sphere every clock cycle (busy never rises) and gives
// its visibility with a one-cycle done strobe; results come
// out in the order the spheres went in. The receiver cannot stall the core,
// so done must be taken when it is shown. Most of the pipeline is the
// restoring divider, one quotient bit per stage over 62 stages, that applies
// the reciprocal of depth to four numerators side by side. Configuration
// writes take effect at once and belong between transactions.
module bounding_sphere_visibility_core #(
    parameter int FRAC_BITS = bsv_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] view_x,
    input  wire logic signed [31:0] view_y,
    input  wire logic signed [31:0] view_z,
    input  wire logic [30:0]        radius,
    input  wire logic [30:0]        scale_x,
    input  wire logic [30:0]        scale_y,
    input  wire logic [30:0]        scale_z,
    output logic                    done,
    output logic [1:0]              visibility,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    localparam int NUM_W = bsv_pkg::NUM_W;
    localparam int REM_W = bsv_pkg::REM_W;
    localparam int PT_W  = bsv_pkg::PT_W;
    localparam int NDIV  = bsv_pkg::NDIV;

    localparam logic [30:0] ONE_31     = 31'(64'd1 << FRAC_BITS);
    localparam logic [30:0] SCALE_RST  = 31'(64'd320 << FRAC_BITS);
    localparam logic [31:0] LEFT_RST   = 32'(64'sd0 - (64'sd320 <<< FRAC_BITS));
    localparam logic [31:0] RIGHT_RST  = 32'(64'sd320 <<< FRAC_BITS);
    localparam logic [31:0] TOP_RST    = 32'(64'sd0 - (64'sd240 <<< FRAC_BITS));
    localparam logic [31:0] BOTTOM_RST = 32'(64'sd240 <<< FRAC_BITS);

    // Configuration registers
    logic [30:0]        near_reg;
    logic [30:0]        hs_reg;
    logic [30:0]        vs_reg;
    logic signed [31:0] left_reg;
    logic signed [31:0] right_reg;
    logic signed [31:0] top_reg;
    logic signed [31:0] bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg   <= ONE_31;
            hs_reg     <= SCALE_RST;
            vs_reg     <= SCALE_RST;
            left_reg   <= LEFT_RST;
            right_reg  <= RIGHT_RST;
            top_reg    <= TOP_RST;
            bottom_reg <= BOTTOM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bsv_pkg::REG_NEAR:   near_reg   <= cfg_data[30:0];
                bsv_pkg::REG_HSCALE: hs_reg     <= cfg_data[30:0];
                bsv_pkg::REG_VSCALE: vs_reg     <= cfg_data[30:0];
                bsv_pkg::REG_LEFT:   left_reg   <= cfg_data;
                bsv_pkg::REG_RIGHT:  right_reg  <= cfg_data;
                bsv_pkg::REG_TOP:    top_reg    <= cfg_data;
                bsv_pkg::REG_BOTTOM: bottom_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 1: capture and pick the largest scale, never less than one.
    logic [30:0] smax_next;
    always_comb
    begin
        smax_next = ONE_31;
        if (scale_x > smax_next) smax_next = scale_x;
        if (scale_y > smax_next) smax_next = scale_y;
        if (scale_z > smax_next) smax_next = scale_z;
    end

    logic               s1_valid_reg;
    logic signed [31:0] s1_vx_reg;
    logic signed [31:0] s1_vy_reg;
    logic signed [31:0] s1_vz_reg;
    logic [30:0]        s1_rad_reg;
    logic [30:0]        s1_scl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_vx_reg  <= view_x;
        s1_vy_reg  <= view_y;
        s1_vz_reg  <= view_z;
        s1_rad_reg <= radius;
        s1_scl_reg <= smax_next;
    end

    // Stage 2: effective radius.
    logic [61:0] rprod;
    assign rprod = s1_rad_reg * s1_scl_reg;

    logic               s2_valid_reg;
    logic signed [31:0] s2_vx_reg;
    logic signed [31:0] s2_vy_reg;
    logic signed [31:0] s2_vz_reg;
    logic [61:0]        s2_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_vx_reg <= s1_vx_reg;
        s2_vy_reg <= s1_vy_reg;
        s2_vz_reg <= s1_vz_reg;
        s2_r_reg  <= rprod >> FRAC_BITS;
    end

    // Stage 3: near-plane test and the four numerator products. In the
    // projected case depth exceeds the radius, so the radius fits 31 bits.
    logic signed [63:0]      vz64;
    logic signed [63:0]      r64;
    logic signed [63:0]      near64;
    bsv_pkg::vis_t           cls_next;
    logic                    proj_next;
    logic signed [62:0]      px_next;
    logic signed [62:0]      py_next;

    always_comb
    begin
        vz64   = 64'(s2_vz_reg);
        r64    = signed'({2'b00, s2_r_reg});
        near64 = signed'({33'd0, near_reg});
        cls_next  = bsv_pkg::VIS_PARTIAL;
        proj_next = 1'b0;
        if (vz64 + r64 < near64)
        begin
            cls_next = bsv_pkg::VIS_NONE;
        end
        else if (!(vz64 - r64 <= near64))
        begin
            proj_next = 1'b1;
        end
        px_next = signed'({1'b0, hs_reg}) * s2_vx_reg;
        py_next = signed'({1'b0, vs_reg}) * s2_vy_reg;
    end

    logic               s3_valid_reg;
    bsv_pkg::vis_t      s3_cls_reg;
    logic               s3_proj_reg;
    logic signed [62:0] s3_px_reg;
    logic signed [62:0] s3_py_reg;
    logic [NUM_W-1:0]   s3_pw_reg;
    logic [NUM_W-1:0]   s3_ph_reg;
    logic [REM_W-1:0]   s3_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_cls_reg  <= cls_next;
        s3_proj_reg <= proj_next;
        s3_px_reg   <= px_next;
        s3_py_reg   <= py_next;
        s3_pw_reg   <= hs_reg * s2_r_reg[30:0];
        s3_ph_reg   <= vs_reg * s2_r_reg[30:0];
        s3_d_reg    <= s2_vz_reg[30:0];
    end

    // Divider pipeline. Entry 0 takes the magnitudes; each following entry
    // resolves one quotient bit of all four divisions.
    logic               dv_reg   [0:NUM_W];
    bsv_pkg::vis_t      dcls_reg [0:NUM_W];
    logic               dproj_reg[0:NUM_W];
    logic               dnx_reg  [0:NUM_W];
    logic               dny_reg  [0:NUM_W];
    logic [REM_W-1:0]   dd_reg   [0:NUM_W];
    logic [REM_W-1:0]   rem_reg  [0:NDIV-1][0:NUM_W];
    logic [NUM_W-1:0]   num_reg  [0:NDIV-1][0:NUM_W];

    logic signed [62:0] nx_neg;
    logic signed [62:0] ny_neg;
    assign nx_neg = -s3_px_reg;
    assign ny_neg = -s3_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dcls_reg[0]   <= s3_cls_reg;
        dproj_reg[0]  <= s3_proj_reg;
        dnx_reg[0]    <= s3_px_reg[62];
        dny_reg[0]    <= s3_py_reg[62];
        dd_reg[0]     <= s3_d_reg;
        num_reg[0][0] <= s3_px_reg[62] ? nx_neg[NUM_W-1:0] : s3_px_reg[NUM_W-1:0];
        num_reg[1][0] <= s3_py_reg[62] ? ny_neg[NUM_W-1:0] : s3_py_reg[NUM_W-1:0];
        num_reg[2][0] <= s3_pw_reg;
        num_reg[3][0] <= s3_ph_reg;
        rem_reg[0][0] <= '0;
        rem_reg[1][0] <= '0;
        rem_reg[2][0] <= '0;
        rem_reg[3][0] <= '0;
    end

    for (genvar s = 0; s < NUM_W; s++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[s+1] <= 1'b0;
            end
            else
            begin
                dv_reg[s+1] <= dv_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            dcls_reg[s+1]  <= dcls_reg[s];
            dproj_reg[s+1] <= dproj_reg[s];
            dnx_reg[s+1]   <= dnx_reg[s];
            dny_reg[s+1]   <= dny_reg[s];
            dd_reg[s+1]    <= dd_reg[s];
        end

        for (genvar q = 0; q < NDIV; q++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                {rem_reg[q][s+1], num_reg[q][s+1]} <=
                    bsv_pkg::div_step(rem_reg[q][s], num_reg[q][s], dd_reg[s]);
            end
        end
    end

    // Post stage 1: floor for negative numerators; screen y is negated.
    logic signed [PT_W-1:0] qx;
    logic signed [PT_W-1:0] qy;
    logic signed [PT_W-1:0] sx_next;
    logic signed [PT_W-1:0] sy_next;
    logic                   rx_nz;
    logic                   ry_nz;

    always_comb
    begin
        qx    = signed'(PT_W'(num_reg[0][NUM_W]));
        qy    = signed'(PT_W'(num_reg[1][NUM_W]));
        rx_nz = (rem_reg[0][NUM_W] != '0);
        ry_nz = (rem_reg[1][NUM_W] != '0);
        sx_next = dnx_reg[NUM_W] ? (-qx - PT_W'(rx_nz)) : qx;
        sy_next = dny_reg[NUM_W] ? (qy + PT_W'(ry_nz)) : -qy;
    end

    logic                   p1_valid_reg;
    bsv_pkg::vis_t          p1_cls_reg;
    logic                   p1_proj_reg;
    logic signed [PT_W-1:0] p1_sx_reg;
    logic signed [PT_W-1:0] p1_sy_reg;
    logic signed [PT_W-1:0] p1_w_reg;
    logic signed [PT_W-1:0] p1_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= dv_reg[NUM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        p1_cls_reg  <= dcls_reg[NUM_W];
        p1_proj_reg <= dproj_reg[NUM_W];
        p1_sx_reg   <= sx_next;
        p1_sy_reg   <= sy_next;
        p1_w_reg    <= signed'(PT_W'(num_reg[2][NUM_W]));
        p1_h_reg    <= signed'(PT_W'(num_reg[3][NUM_W]));
    end

    // Post stage 2: outcodes at the centre and the four extremal points.
    logic [3:0] oc0;
    logic [3:0] oc1;
    logic [3:0] oc2;
    logic [3:0] oc3;
    logic [3:0] oc4;

    always_comb
    begin
        oc0 = bsv_pkg::outcode(p1_sx_reg, p1_sy_reg,
                               left_reg, right_reg, top_reg, bottom_reg);
        oc1 = bsv_pkg::outcode(p1_sx_reg + p1_w_reg, p1_sy_reg,
                               left_reg, right_reg, top_reg, bottom_reg);
        oc2 = bsv_pkg::outcode(p1_sx_reg, p1_sy_reg + p1_h_reg,
                               left_reg, right_reg, top_reg, bottom_reg);
        oc3 = bsv_pkg::outcode(p1_sx_reg - p1_w_reg, p1_sy_reg,
                               left_reg, right_reg, top_reg, bottom_reg);
        oc4 = bsv_pkg::outcode(p1_sx_reg, p1_sy_reg - p1_h_reg,
                               left_reg, right_reg, top_reg, bottom_reg);
    end

    logic          p2_valid_reg;
    bsv_pkg::vis_t p2_cls_reg;
    logic          p2_proj_reg;
    logic [3:0]    p2_any_reg;
    logic [3:0]    p2_all_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_cls_reg  <= p1_cls_reg;
        p2_proj_reg <= p1_proj_reg;
        p2_any_reg  <= oc0 | oc1 | oc2 | oc3 | oc4;
        p2_all_reg  <= oc0 & oc1 & oc2 & oc3 & oc4;
    end

    // Output register.
    bsv_pkg::vis_t vis_next;
    always_comb
    begin
        vis_next = p2_cls_reg;
        if (p2_proj_reg)
        begin
            if (p2_all_reg != 4'd0)
            begin
                vis_next = bsv_pkg::VIS_NONE;
            end
            else if (p2_any_reg == 4'd0)
            begin
                vis_next = bsv_pkg::VIS_FULL;
            end
            else
            begin
                vis_next = bsv_pkg::VIS_PARTIAL;
            end
        end
    end

    logic          done_reg;
    bsv_pkg::vis_t vis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        vis_reg <= vis_next;
    end

    assign done       = done_reg;
    assign visibility = vis_reg;

endmodule

`default_nettype wire
